/* sv/nslt_pkg.sv */
// ----------------------------------------------------------------------------
// nslt_pkg
// Shared constants, codes and control types for the name/socket lookup table.
// ----------------------------------------------------------------------------
package nslt_pkg;

    localparam int CAPACITY   = 16;
    localparam int NAME_BYTES = 128;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int BYTE_W = $clog2(NAME_BYTES);
    localparam int LEN_W  = $clog2(NAME_BYTES + 1);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_SLOT_W = 4;
    localparam int OUT_CNT_W  = 5;
    localparam int SOCK_W     = 16;

    localparam logic [CMD_W-1:0] CMD_ADD       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND_NAME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_SOCK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic                stage_en;
        logic                latch;
        logic                slot_clr;
        logic                slot_inc;
        logic                byte_clr;
        logic                byte_inc;
        logic                name_wr;
        logic                add_commit;
        logic                remove_commit;
        logic                res_set;
        logic [STATUS_W-1:0] res_code;
        logic                out_load;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             slot_last;
        logic             slot_free;
        logic             sock_hit;
        logic             len_eq;
        logic             byte_eq;
        logic             byte_last;
        logic             staged_empty;
        logic             out_busy;
    } stat_t;

endpackage

/* sv/nslt_ctrl.sv */
// ----------------------------------------------------------------------------
// nslt_ctrl
// Sequencer that walks the slots and name bytes for each request.
// ----------------------------------------------------------------------------
module nslt_ctrl
    import nslt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CMD_W-1:0] command,
    input  logic             name_last,
    input  stat_t            stat,
    output ctl_t             ctl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_CMP_RD   = 3'd2;
    localparam logic [2:0] S_CMP_CHK  = 3'd3;
    localparam logic [2:0] S_COPY_RD  = 3'd4;
    localparam logic [2:0] S_COPY_WR  = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.res_code = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_FIND_SOCK)
                    begin
                        ctl.latch    = 1'b1;
                        ctl.slot_clr = 1'b1;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        ctl.stage_en = 1'b1;
                        if (name_last)
                        begin
                            ctl.latch    = 1'b1;
                            ctl.slot_clr = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                case (stat.op)
                    CMD_FIND_SOCK:
                    begin
                        if (stat.sock_hit)
                        begin
                            ctl.res_set = 1'b1;
                            state_next  = S_RESP;
                        end
                        else if (stat.slot_last)
                        begin
                            ctl.res_set  = 1'b1;
                            ctl.res_code = ST_NOT_FOUND;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            ctl.slot_inc = 1'b1;
                        end
                    end
                    CMD_ADD:
                    begin
                        if (stat.slot_free)
                        begin
                            if (stat.staged_empty)
                            begin
                                ctl.add_commit = 1'b1;
                                ctl.res_set    = 1'b1;
                                state_next     = S_RESP;
                            end
                            else
                            begin
                                ctl.byte_clr = 1'b1;
                                state_next   = S_COPY_RD;
                            end
                        end
                        else if (stat.slot_last)
                        begin
                            ctl.res_set  = 1'b1;
                            ctl.res_code = ST_FULL;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            ctl.slot_inc = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (stat.len_eq)
                        begin
                            ctl.byte_clr = 1'b1;
                            state_next   = S_CMP_RD;
                        end
                        else if (stat.slot_last)
                        begin
                            ctl.res_set  = 1'b1;
                            ctl.res_code = ST_NOT_FOUND;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            ctl.slot_inc = 1'b1;
                        end
                    end
                endcase
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (!stat.byte_eq)
                begin
                    if (stat.slot_last)
                    begin
                        ctl.res_set  = 1'b1;
                        ctl.res_code = ST_NOT_FOUND;
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        ctl.slot_inc = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
                else if (stat.byte_last)
                begin
                    ctl.remove_commit = (stat.op == CMD_REMOVE);
                    ctl.res_set       = 1'b1;
                    state_next        = S_RESP;
                end
                else
                begin
                    ctl.byte_inc = 1'b1;
                    state_next   = S_CMP_RD;
                end
            end
            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                ctl.name_wr = 1'b1;
                if (stat.byte_last)
                begin
                    ctl.add_commit = 1'b1;
                    ctl.res_set    = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    ctl.byte_inc = 1'b1;
                    state_next   = S_COPY_RD;
                end
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/nslt_dpath.sv */
// ----------------------------------------------------------------------------
// nslt_dpath
// Name and staging memories, slot metadata, counters and the result register.
// ----------------------------------------------------------------------------
module nslt_dpath
    import nslt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_t                  ctl,
    output stat_t                 stat,
    input  logic [CMD_W-1:0]      command,
    input  logic [7:0]            name_byte,
    input  logic [SOCK_W-1:0]     socket,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [OUT_SLOT_W-1:0] slot_index,
    output logic [OUT_CNT_W-1:0]  entry_count
);

    localparam int NAME_DEPTH = (2 ** SLOT_W) * (2 ** BYTE_W);

    logic [7:0]            name_mem [NAME_DEPTH];
    logic [7:0]            staged_mem [NAME_BYTES];
    logic [7:0]            name_rd_reg;
    logic [7:0]            staged_rd_reg;

    logic [LEN_W-1:0]      len_reg [CAPACITY];
    logic [SOCK_W-1:0]     sock_reg [CAPACITY];
    logic [LEN_W-1:0]      staged_len_reg;
    logic [CNT_W-1:0]      count_reg;

    logic [SLOT_W-1:0]     slot_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic [CMD_W-1:0]      op_reg;
    logic [SOCK_W-1:0]     req_sock_reg;

    logic [STATUS_W-1:0]   res_status_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic [LEN_W-1:0]      cur_len;
    logic [SOCK_W-1:0]     cur_sock;
    logic                  stage_ok;

    assign cur_len  = len_reg[slot_reg];
    assign cur_sock = sock_reg[slot_reg];
    assign stage_ok = ctl.stage_en && (name_byte != 8'd0)
                      && (staged_len_reg < LEN_W'(NAME_BYTES));

    always_comb
    begin
        stat.op           = op_reg;
        stat.slot_last    = (slot_reg == SLOT_W'(CAPACITY - 1));
        stat.slot_free    = (cur_len == '0) && (cur_sock == '0);
        stat.sock_hit     = (cur_len != '0) && (cur_sock == req_sock_reg);
        stat.len_eq       = (cur_len != '0) && (cur_len == staged_len_reg);
        stat.byte_eq      = (name_rd_reg == staged_rd_reg);
        stat.byte_last    = ((LEN_W'(byte_reg) + LEN_W'(1)) == staged_len_reg);
        stat.staged_empty = (staged_len_reg == '0);
        stat.out_busy     = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ok)
        begin
            staged_mem[staged_len_reg[BYTE_W-1:0]] <= name_byte;
        end
        staged_rd_reg <= staged_mem[byte_reg];
        if (ctl.name_wr)
        begin
            name_mem[{slot_reg, byte_reg}] <= staged_rd_reg;
        end
        name_rd_reg <= name_mem[{slot_reg, byte_reg}];
        if (ctl.latch)
        begin
            op_reg       <= command;
            req_sock_reg <= socket;
        end
        if (ctl.res_set)
        begin
            res_status_reg <= ctl.res_code;
            res_slot_reg   <= (ctl.res_code == ST_OK) ? slot_reg : '0;
        end
        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_count_reg  <= count_reg;
        end
        if (ctl.slot_clr)
        begin
            slot_reg <= '0;
        end
        else if (ctl.slot_inc)
        begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end
        if (ctl.byte_clr)
        begin
            byte_reg <= '0;
        end
        else if (ctl.byte_inc)
        begin
            byte_reg <= byte_reg + BYTE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                len_reg[i]  <= '0;
                sock_reg[i] <= '0;
            end
            staged_len_reg <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.res_set && (op_reg != CMD_FIND_SOCK))
            begin
                staged_len_reg <= '0;
            end
            else if (stage_ok)
            begin
                staged_len_reg <= staged_len_reg + LEN_W'(1);
            end
            if (ctl.add_commit)
            begin
                len_reg[slot_reg]  <= staged_len_reg;
                sock_reg[slot_reg] <= req_sock_reg;
                if (count_reg < CNT_W'(CAPACITY))
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            else if (ctl.remove_commit)
            begin
                len_reg[slot_reg]  <= '0;
                sock_reg[slot_reg] <= '0;
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot_index  = OUT_SLOT_W'(out_slot_reg);
    assign entry_count = OUT_CNT_W'(out_count_reg);

endmodule

/* sv/name_socket_lookup_table.sv */
// ----------------------------------------------------------------------------
// name_socket_lookup_table
// Fixed table of named slots, each holding a socket number.
// ----------------------------------------------------------------------------
// Each input beat is one item; name requests stream one byte per item and run on
// the item marked last, while a find by socket runs on its own item. A run
// walks the slots one per cycle, pausing while a candidate name is compared,
// and compares that name byte by byte through the registered name memory,
// reading in S_CMP_RD and checking in S_CMP_CHK; an add copies the name byte
// by byte, reading in S_COPY_RD and writing in S_COPY_WR. Input is held off
// while a run is active. There is no clearing pass after reset.
module name_socket_lookup_table
    import nslt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [7:0]            name_byte,
    input  logic                  name_last,
    input  logic [SOCK_W-1:0]     socket,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [OUT_SLOT_W-1:0] slot_index,
    output logic [OUT_CNT_W-1:0]  entry_count
);

    ctl_t  ctl;
    stat_t stat;

    nslt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .name_last (name_last),
        .stat      (stat),
        .ctl       (ctl)
    );

    nslt_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .command     (command),
        .name_byte   (name_byte),
        .socket      (socket),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .slot_index  (slot_index),
        .entry_count (entry_count)
    );

endmodule
